// ===== design/stt_pkg.sv =====
// Types, token and error codes, keyword table and character helpers for the tokenizer.
package stt_pkg;

    localparam int TOKEN_OFFSET_W = 24;
    localparam int TOKEN_LINE_W   = 20;
    localparam int DEF_OFFSET_BITS     = 24;
    localparam int DEF_LINE_BITS       = 20;
    localparam int DEF_MAX_KEYWORD_LEN = 9;
    localparam int MAX_RESULTS = 4;
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] source_byte;
        logic       end_of_source;
    } byte_item_t;

    typedef struct packed {
        logic [6:0]                token_kind;
        logic [3:0]                error_kind;
        logic [TOKEN_OFFSET_W-1:0] start_offset;
        logic [TOKEN_OFFSET_W-1:0] lexeme_length;
        logic [TOKEN_LINE_W-1:0]   line_number;
        logic                      last_token;
    } token_t;

    // Token kinds
    localparam logic [6:0] K_LPAREN = 7'd0,   K_RPAREN = 7'd1,   K_LBRACE = 7'd2;
    localparam logic [6:0] K_RBRACE = 7'd3,   K_LBRACK = 7'd4,   K_RBRACK = 7'd5;
    localparam logic [6:0] K_COMMA = 7'd6,    K_DOT = 7'd7,      K_ELLIPSIS = 7'd8;
    localparam logic [6:0] K_RANGE = 7'd9,    K_COLON = 7'd10,   K_SEMI = 7'd11;
    localparam logic [6:0] K_QUEST = 7'd12,   K_PLUS = 7'd13,    K_INC = 7'd14;
    localparam logic [6:0] K_PLUS_EQ = 7'd15, K_MINUS = 7'd16,   K_DEC = 7'd17;
    localparam logic [6:0] K_MINUS_EQ = 7'd18, K_ARROW = 7'd19,  K_STAR = 7'd20;
    localparam logic [6:0] K_STAR_EQ = 7'd21, K_SLASH = 7'd22,   K_SLASH_EQ = 7'd23;
    localparam logic [6:0] K_PERCENT = 7'd24, K_PERCENT_EQ = 7'd25, K_AMP = 7'd26;
    localparam logic [6:0] K_AMP_EQ = 7'd27,  K_AND_AND = 7'd28, K_PIPE = 7'd29;
    localparam logic [6:0] K_PIPE_EQ = 7'd30, K_OR_OR = 7'd31,   K_CARET = 7'd32;
    localparam logic [6:0] K_CARET_EQ = 7'd33, K_BANG = 7'd34,   K_BANG_EQ = 7'd35;
    localparam logic [6:0] K_ASSIGN = 7'd36,  K_EQ_EQ = 7'd37,   K_FAT_ARROW = 7'd38;
    localparam logic [6:0] K_LT = 7'd39,      K_LT_EQ = 7'd40,   K_SHL = 7'd41;
    localparam logic [6:0] K_GT = 7'd42,      K_GT_EQ = 7'd43,   K_SHR = 7'd44;
    localparam logic [6:0] K_UNDERSCORE = 7'd45, K_IDENT = 7'd46, K_INT = 7'd47;
    localparam logic [6:0] K_FLOAT = 7'd48,   K_HEX = 7'd49,     K_BIN = 7'd50;
    localparam logic [6:0] K_STRING = 7'd51,  K_CHAR = 7'd52,    K_KW_BASE = 7'd53;
    localparam logic [6:0] K_ERROR = 7'd86,   K_END = 7'd87;

    // Error kinds
    localparam logic [3:0] E_NONE = 4'd0;
    localparam logic [3:0] E_UNEXPECTED = 4'd0, E_EXPONENT = 4'd1, E_STR = 4'd2;
    localparam logic [3:0] E_RAW = 4'd3, E_CHEX = 4'd4, E_CESC = 4'd5;
    localparam logic [3:0] E_CEMPTY = 4'd6, E_CUNTERM = 4'd7, E_CINVALID = 4'd8;

    localparam int KW_COUNT = 33;
    localparam int KW_CHARS = 9;

    localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
        "func", "let", "const", "return", "if", "else", "for", "while", "match",
        "extern", "struct", "static", "typealias", "defer", "break", "continue",
        "cast", "true", "false", "null", "u8", "i8", "char", "u16", "i16", "u32",
        "i32", "u64", "i64", "f32", "f64", "bool", "void"
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd4, 4'd3, 4'd5, 4'd6, 4'd2, 4'd4, 4'd3, 4'd5, 4'd5, 4'd6, 4'd6, 4'd6,
        4'd9, 4'd5, 4'd5, 4'd8, 4'd4, 4'd4, 4'd5, 4'd4, 4'd2, 4'd2, 4'd4, 4'd3,
        4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4
    };

    // Character i of keyword k, counted from the first; zero past its end
    function automatic logic [7:0] kw_byte(int k, int i);
        logic [7:0] b;
        b = 8'd0;
        if (i < int'(KW_LEN[k]))
        begin
            b = KW_TEXT[k][8*(int'(KW_LEN[k]) - 1 - i) +: 8];
        end
        return b;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_hex(logic [7:0] c);
        return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction

    function automatic logic is_print(logic [7:0] c);
        return (c >= 8'h20) && (c <= 8'h7E);
    endfunction

    function automatic logic [6:0] op_single(logic [7:0] f);
        logic [6:0] k;
        case (f)
            "+":     k = K_PLUS;
            "-":     k = K_MINUS;
            "*":     k = K_STAR;
            "/":     k = K_SLASH;
            "%":     k = K_PERCENT;
            "&":     k = K_AMP;
            "|":     k = K_PIPE;
            "^":     k = K_CARET;
            "!":     k = K_BANG;
            "=":     k = K_ASSIGN;
            "<":     k = K_LT;
            ">":     k = K_GT;
            default: k = K_DOT;
        endcase
        return k;
    endfunction

    // Bit 7 set when the two bytes form a two-character operator
    function automatic logic [7:0] op_pair(logic [7:0] f, logic [7:0] s);
        logic [7:0] r;
        r = 8'd0;
        case (f)
            "+":
            begin
                if (s == "+") r = {1'b1, K_INC};
                else if (s == "=") r = {1'b1, K_PLUS_EQ};
            end
            "-":
            begin
                if (s == "-") r = {1'b1, K_DEC};
                else if (s == "=") r = {1'b1, K_MINUS_EQ};
                else if (s == ">") r = {1'b1, K_ARROW};
            end
            "*": if (s == "=") r = {1'b1, K_STAR_EQ};
            "/": if (s == "=") r = {1'b1, K_SLASH_EQ};
            "%": if (s == "=") r = {1'b1, K_PERCENT_EQ};
            "&":
            begin
                if (s == "=") r = {1'b1, K_AMP_EQ};
                else if (s == "&") r = {1'b1, K_AND_AND};
            end
            "|":
            begin
                if (s == "=") r = {1'b1, K_PIPE_EQ};
                else if (s == "|") r = {1'b1, K_OR_OR};
            end
            "^": if (s == "=") r = {1'b1, K_CARET_EQ};
            "!": if (s == "=") r = {1'b1, K_BANG_EQ};
            "=":
            begin
                if (s == "=") r = {1'b1, K_EQ_EQ};
                else if (s == ">") r = {1'b1, K_FAT_ARROW};
            end
            "<":
            begin
                if (s == "=") r = {1'b1, K_LT_EQ};
                else if (s == "<") r = {1'b1, K_SHL};
            end
            ">":
            begin
                if (s == "=") r = {1'b1, K_GT_EQ};
                else if (s == ">") r = {1'b1, K_SHR};
            end
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/source_text_tokenizer.sv =====
// Streaming source tokenizer: one byte in, up to four tokens out per byte.
// Usage: one source byte is taken per clock while byte_stall is low. A taken
// byte sits in an input register and, once the queue has room, is scanned by
// the mode logic, which rescans it in the new mode when a mode hands it on,
// and a parallel keyword compare; its tokens (at most four) go into an
// eight-entry token queue, and a byte is scanned only while the queue has room
// for four. Tokens leave the queue one per cycle while token_stall is low, so
// the input runs at one byte per cycle as long as bytes average one token or
// fewer. A NUL or end_of_source byte closes the source: the pending token is
// flushed, an end token follows, later bytes are taken and dropped until reset.
module source_text_tokenizer #(
    parameter int OFFSET_BITS     = stt_pkg::DEF_OFFSET_BITS,
    parameter int LINE_BITS       = stt_pkg::DEF_LINE_BITS,
    parameter int MAX_KEYWORD_LEN = stt_pkg::DEF_MAX_KEYWORD_LEN
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  stt_pkg::byte_item_t byte_item,
    output logic                token_valid,
    input  logic                token_stall,
    output stt_pkg::token_t     token_item
);
    import stt_pkg::*;

    typedef enum logic [4:0] {
        M_IDLE, M_OP1, M_DOT2, M_LCOM, M_BCOM, M_BSTAR, M_WORD, M_NZERO, M_INT,
        M_HEX, M_BIN, M_NDOT, M_FRAC, M_EXPS, M_EXPSIGN, M_EXPD, M_SO1, M_SO2,
        M_STR, M_SESC, M_RAW, M_RESC, M_CO, M_CESC, M_CHEX0, M_CHEX1, M_CDEC,
        M_CCLOSE
    } mode_t;

    typedef logic [MAX_KEYWORD_LEN-1:0][7:0] word_buf_t;
    typedef logic [OFFSET_BITS-1:0] off_t;
    typedef logic [LINE_BITS-1:0] line_t;

    localparam int PASS_LIMIT = 4;
    localparam logic [7:0] CH_CR = 8'h0D;

    function automatic token_t mk_tok(logic [6:0] kind, logic [3:0] err, off_t start,
                                      off_t stop, line_t line, logic last);
        token_t t;
        off_t   len;
        len = stop - start;
        t.token_kind    = kind;
        t.error_kind    = err;
        t.start_offset  = TOKEN_OFFSET_W'(start);
        t.lexeme_length = TOKEN_OFFSET_W'(len);
        t.line_number   = TOKEN_LINE_W'(line);
        t.last_token    = last;
        return t;
    endfunction

    function automatic logic [6:0] word_kind(word_buf_t wb, off_t len);
        logic [6:0] k;
        logic       found;
        logic       hit;
        k = K_IDENT;
        found = 1'b0;
        for (int kx = 0; kx < KW_COUNT; kx++)
        begin
            hit = (len == OFFSET_BITS'(KW_LEN[kx]));
            for (int i = 0; i < MAX_KEYWORD_LEN; i++)
            begin
                if ((i < int'(KW_LEN[kx])) && (wb[i] != kw_byte(kx, i)))
                begin
                    hit = 1'b0;
                end
            end
            if (hit && !found)
            begin
                k = K_KW_BASE + 7'(kx);
                found = 1'b1;
            end
        end
        return k;
    endfunction

    mode_t      mode_reg, mode_next;
    off_t       tstart_reg, tstart_next;
    off_t       pos_reg, pos_next;
    line_t      line_reg, line_next;
    word_buf_t  word_reg, word_next;
    logic [7:0] pend_reg, pend_next;
    logic [1:0] esc_reg, esc_next;
    logic       ended_reg, ended_next;

    logic       held_valid_reg, held_valid_next;
    byte_item_t held_item_reg;

    token_t            queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    token_t     res [MAX_RESULTS];
    logic [2:0] push_n;
    logic       proceed;
    logic       accept;
    logic       pop;

    assign proceed    = held_valid_reg
                        && (count_reg <= QCNT_W'(QUEUE_DEPTH - MAX_RESULTS));
    assign byte_stall = held_valid_reg && !proceed;
    assign accept     = byte_valid && !byte_stall;
    assign token_valid = (count_reg != '0);
    assign token_item  = queue_reg[rd_ptr_reg];
    assign pop         = token_valid && !token_stall;

    always_comb
    begin
        held_valid_next = held_valid_reg;
        if (accept)
            held_valid_next = 1'b1;
        else if (proceed)
            held_valid_next = 1'b0;
    end

    always_comb
    begin
        mode_t      mode;
        off_t       tstart, pos, endpos;
        line_t      line;
        word_buf_t  word;
        logic [7:0] pend, c, pk;
        logic [1:0] esc;
        logic       cont, done, fin, e_do;
        token_t     e_tok;
        logic [6:0] wk_feed;
        off_t       idx;

        mode   = mode_reg;
        tstart = tstart_reg;
        pos    = pos_reg;
        line   = line_reg;
        word   = word_reg;
        pend   = pend_reg;
        esc    = esc_reg;
        c      = held_item_reg.source_byte;
        endpos = pos_reg;
        fin    = 1'b0;
        done   = 1'b0;
        cont   = 1'b0;
        e_do   = 1'b0;
        e_tok  = '0;
        pk     = 8'd0;
        idx    = '0;
        push_n = 3'd0;
        for (int j = 0; j < MAX_RESULTS; j++)
            res[j] = '0;
        wk_feed = word_kind(word_reg, pos_reg - tstart_reg);
        ended_next = ended_reg;

        if (proceed && !ended_reg)
        begin
            if (c == 8'd0)
            begin
                fin = 1'b1;
                endpos = pos_reg;
            end
            else
            begin
                for (int p = 0; p < PASS_LIMIT; p++)
                begin
                    if (!done)
                    begin
                        cont = 1'b0;
                        e_do = 1'b0;
                        unique case (mode)
                            M_OP1:
                            begin
                                pk = op_pair(pend, c);
                                if (pend == "." && c == ".")
                                    mode = M_DOT2;
                                else if (pend == "/" && c == "/")
                                    mode = M_LCOM;
                                else if (pend == "/" && c == "*")
                                    mode = M_BCOM;
                                else
                                begin
                                    mode = M_IDLE;
                                    e_do = 1'b1;
                                    if (pk[7])
                                        e_tok = mk_tok(pk[6:0], E_NONE, tstart, pos + 1'b1,
                                                       line, 1'b0);
                                    else
                                    begin
                                        e_tok = mk_tok(op_single(pend), E_NONE, tstart, pos,
                                                       line, 1'b0);
                                        cont = 1'b1;
                                    end
                                end
                            end
                            M_DOT2:
                            begin
                                mode = M_IDLE;
                                e_do = 1'b1;
                                if (c == ".")
                                    e_tok = mk_tok(K_ELLIPSIS, E_NONE, tstart, pos + 1'b1,
                                                   line, 1'b0);
                                else
                                begin
                                    e_tok = mk_tok(K_RANGE, E_NONE, tstart, pos, line, 1'b0);
                                    cont = 1'b1;
                                end
                            end
                            M_LCOM:
                            begin
                                if (c == "\n")
                                begin
                                    if (line != '1) line = line + 1'b1;
                                    mode = M_IDLE;
                                end
                            end
                            M_BCOM:
                            begin
                                if (c == "*")
                                    mode = M_BSTAR;
                                else if (c == "\n" && line != '1)
                                    line = line + 1'b1;
                            end
                            M_BSTAR:
                            begin
                                if (c == "/")
                                    mode = M_IDLE;
                                else if (c != "*")
                                begin
                                    mode = M_BCOM;
                                    if (c == "\n" && line != '1) line = line + 1'b1;
                                end
                            end
                            M_WORD:
                            begin
                                if (is_alpha(c) || is_digit(c) || c == "_")
                                begin
                                    idx = pos - tstart;
                                    for (int j = 0; j < MAX_KEYWORD_LEN; j++)
                                        if (idx == OFFSET_BITS'(j)) word[j] = c;
                                end
                                else
                                begin
                                    e_do = 1'b1;
                                    e_tok = mk_tok(wk_feed, E_NONE, tstart, pos, line, 1'b0);
                                    mode = M_IDLE;
                                    cont = 1'b1;
                                end
                            end
                            M_NZERO:
                            begin
                                if (c == "x" || c == "X")
                                    mode = M_HEX;
                                else if (c == "b" || c == "B")
                                    mode = M_BIN;
                                else
                                begin
                                    mode = M_INT;
                                    cont = 1'b1;
                                end
                            end
                            M_INT:
                            begin
                                if (c == ".")
                                    mode = M_NDOT;
                                else if (c == "e" || c == "E")
                                    mode = M_EXPS;
                                else if (!is_digit(c))
                                begin
                                    e_do = 1'b1;
                                    e_tok = mk_tok(K_INT, E_NONE, tstart, pos, line, 1'b0);
                                    mode = M_IDLE;
                                    cont = 1'b1;
                                end
                            end
                            M_HEX:
                            begin
                                if (!is_hex(c))
                                begin
                                    e_do = 1'b1;
                                    e_tok = mk_tok(K_HEX, E_NONE, tstart, pos, line, 1'b0);
                                    mode = M_IDLE;
                                    cont = 1'b1;
                                end
                            end
                            M_BIN:
                            begin
                                if (c != "0" && c != "1")
                                begin
                                    e_do = 1'b1;
                                    e_tok = mk_tok(K_BIN, E_NONE, tstart, pos, line, 1'b0);
                                    mode = M_IDLE;
                                    cont = 1'b1;
                                end
                            end
                            M_NDOT:
                            begin
                                if (is_digit(c))
                                    mode = M_FRAC;
                                else
                                begin
                                    // int ends before the held dot; rescan the dot
                                    e_do = 1'b1;
                                    e_tok = mk_tok(K_INT, E_NONE, tstart, pos - 1'b1, line,
                                                   1'b0);
                                    tstart = pos - 1'b1;
                                    pend = ".";
                                    mode = M_OP1;
                                    cont = 1'b1;
                                end
                            end
                            M_FRAC:
                            begin
                                if (c == "e" || c == "E")
                                    mode = M_EXPS;
                                else if (!is_digit(c))
                                begin
                                    e_do = 1'b1;
                                    e_tok = mk_tok(K_FLOAT, E_NONE, tstart, pos, line, 1'b0);
                                    mode = M_IDLE;
                                    cont = 1'b1;
                                end
                            end
                            M_EXPS:
                            begin
                                if (c == "+" || c == "-")
                                    mode = M_EXPSIGN;
                                else if (is_digit(c))
                                    mode = M_EXPD;
                                else
                                begin
                                    e_do = 1'b1;
                                    e_tok = mk_tok(K_ERROR, E_EXPONENT, tstart, pos, line,
                                                   1'b0);
                                    mode = M_IDLE;
                                    cont = 1'b1;
                                end
                            end
                            M_EXPSIGN:
                            begin
                                if (is_digit(c))
                                    mode = M_EXPD;
                                else
                                begin
                                    e_do = 1'b1;
                                    e_tok = mk_tok(K_ERROR, E_EXPONENT, tstart, pos, line,
                                                   1'b0);
                                    mode = M_IDLE;
                                    cont = 1'b1;
                                end
                            end
                            M_EXPD:
                            begin
                                if (!is_digit(c))
                                begin
                                    e_do = 1'b1;
                                    e_tok = mk_tok(K_FLOAT, E_NONE, tstart, pos, line, 1'b0);
                                    mode = M_IDLE;
                                    cont = 1'b1;
                                end
                            end
                            M_SO1:
                            begin
                                if (c == "\"")
                                    mode = M_SO2;
                                else
                                begin
                                    mode = M_STR;
                                    cont = 1'b1;
                                end
                            end
                            M_SO2:
                            begin
                                if (c == "\"")
                                begin
                                    mode = M_RAW;
                                    esc = 2'd0;
                                end
                                else
                                begin
                                    // empty string
                                    e_do = 1'b1;
                                    e_tok = mk_tok(K_STRING, E_NONE, tstart, pos, line, 1'b0);
                                    mode = M_IDLE;
                                    cont = 1'b1;
                                end
                            end
                            M_STR:
                            begin
                                if (c == "\"")
                                begin
                                    e_do = 1'b1;
                                    e_tok = mk_tok(K_STRING, E_NONE, tstart, pos + 1'b1, line,
                                                   1'b0);
                                    mode = M_IDLE;
                                end
                                else if (c == "\n")
                                begin
                                    e_do = 1'b1;
                                    e_tok = mk_tok(K_ERROR, E_STR, tstart, pos, line, 1'b0);
                                    mode = M_IDLE;
                                    cont = 1'b1;
                                end
                                else if (c == "\\")
                                    mode = M_SESC;
                            end
                            M_SESC:
                            begin
                                mode = M_STR;
                                cont = !(c == "\"" || c == "\\");
                            end
                            M_RAW:
                            begin
                                if (c == "\"")
                                begin
                                    if (esc >= 2'd2)
                                    begin
                                        e_do = 1'b1;
                                        e_tok = mk_tok(K_STRING, E_NONE, tstart, pos + 1'b1,
                                                       line, 1'b0);
                                        mode = M_IDLE;
                                        esc = 2'd0;
                                    end
                                    else
                                        esc = esc + 2'd1;
                                end
                                else
                                begin
                                    esc = 2'd0;
                                    if (c == "\\")
                                        mode = M_RESC;
                                    else if (c == "\n" && line != '1)
                                        line = line + 1'b1;
                                end
                            end
                            M_RESC:
                            begin
                                mode = M_RAW;
                                cont = !(c == "\"" || c == "\\");
                            end
                            M_CO:
                            begin
                                if (c == "\\")
                                    mode = M_CESC;
                                else if (is_print(c) && c != "'")
                                    mode = M_CCLOSE;
                                else
                                begin
                                    mode = M_IDLE;
                                    e_do = 1'b1;
                                    e_tok = mk_tok(K_ERROR,
                                                   (c == "'") ? E_CEMPTY :
                                                   (c == "\n") ? E_CUNTERM : E_CINVALID,
                                                   tstart, pos, line, 1'b0);
                                    cont = 1'b1;
                                end
                            end
                            M_CESC:
                            begin
                                if (c == "n" || c == "r" || c == "t" || c == "\\"
                                    || c == "'" || c == "\"")
                                    mode = M_CCLOSE;
                                else if (c == "x")
                                    mode = M_CHEX0;
                                else if (is_digit(c))
                                begin
                                    mode = M_CDEC;
                                    esc = 2'd1;
                                end
                                else
                                begin
                                    e_do = 1'b1;
                                    e_tok = mk_tok(K_ERROR, E_CESC, tstart, pos, line, 1'b0);
                                    mode = M_IDLE;
                                    cont = 1'b1;
                                end
                            end
                            M_CHEX0:
                            begin
                                if (is_hex(c))
                                    mode = M_CHEX1;
                                else
                                begin
                                    e_do = 1'b1;
                                    e_tok = mk_tok(K_ERROR, E_CHEX, tstart, pos, line, 1'b0);
                                    mode = M_IDLE;
                                    cont = 1'b1;
                                end
                            end
                            M_CHEX1:
                            begin
                                mode = M_CCLOSE;
                                cont = !is_hex(c);
                            end
                            M_CDEC:
                            begin
                                if (is_digit(c))
                                begin
                                    esc = esc + 2'd1;
                                    if (esc == 2'd3)
                                    begin
                                        mode = M_CCLOSE;
                                        esc = 2'd0;
                                    end
                                end
                                else
                                begin
                                    mode = M_CCLOSE;
                                    esc = 2'd0;
                                    cont = 1'b1;
                                end
                            end
                            M_CCLOSE:
                            begin
                                mode = M_IDLE;
                                e_do = 1'b1;
                                if (c == "'")
                                    e_tok = mk_tok(K_CHAR, E_NONE, tstart, pos + 1'b1, line,
                                                   1'b0);
                                else
                                begin
                                    e_tok = mk_tok(K_ERROR, E_CUNTERM, tstart, pos, line,
                                                   1'b0);
                                    cont = 1'b1;
                                end
                            end
                            default:
                            begin
                                mode = M_IDLE;
                                tstart = pos;
                                case (c) inside
                                    "(", ")", "{", "}", "[", "]", ",", ":", ";", "?", "_":
                                    begin
                                        e_do = 1'b1;
                                        e_tok = mk_tok(
                                            (c == "(") ? K_LPAREN : (c == ")") ? K_RPAREN :
                                            (c == "{") ? K_LBRACE : (c == "}") ? K_RBRACE :
                                            (c == "[") ? K_LBRACK : (c == "]") ? K_RBRACK :
                                            (c == ",") ? K_COMMA  : (c == ":") ? K_COLON :
                                            (c == ";") ? K_SEMI   : (c == "?") ? K_QUEST :
                                            K_UNDERSCORE,
                                            E_NONE, tstart, pos + 1'b1, line, 1'b0);
                                    end
                                    ".", "+", "-", "*", "/", "%", "&", "|", "^", "!", "=",
                                    "<", ">":
                                    begin
                                        pend = c;
                                        mode = M_OP1;
                                    end
                                    "\"": mode = M_SO1;
                                    "'":  mode = M_CO;
                                    " ", CH_CR, "\t": ;
                                    "\n":
                                    begin
                                        if (line != '1) line = line + 1'b1;
                                    end
                                    default:
                                    begin
                                        if (is_alpha(c))
                                        begin
                                            word = '0;
                                            word[0] = c;
                                            mode = M_WORD;
                                        end
                                        else if (is_digit(c))
                                            mode = (c == "0") ? M_NZERO : M_INT;
                                        else
                                        begin
                                            e_do = 1'b1;
                                            e_tok = mk_tok(K_ERROR, E_UNEXPECTED, tstart,
                                                           pos + 1'b1, line, 1'b0);
                                        end
                                    end
                                endcase
                            end
                        endcase
                        if (e_do)
                        begin
                            for (int j = 0; j < MAX_RESULTS; j++)
                                if (push_n == 3'(j)) res[j] = e_tok;
                            push_n = push_n + 3'd1;
                        end
                        done = !cont;
                    end
                end
                pos = pos_reg + 1'b1;
                if (held_item_reg.end_of_source)
                begin
                    fin = 1'b1;
                    endpos = pos;
                end
            end

            if (fin)
            begin
                // flush the pending token, then append the end token
                e_do = 1'b1;
                unique case (mode)
                    M_OP1:
                        e_tok = mk_tok(op_single(pend), E_NONE, tstart, endpos, line, 1'b0);
                    M_DOT2:
                        e_tok = mk_tok(K_RANGE, E_NONE, tstart, endpos, line, 1'b0);
                    M_WORD:
                        e_tok = mk_tok(word_kind(word, endpos - tstart), E_NONE, tstart,
                                       endpos, line, 1'b0);
                    M_NZERO, M_INT:
                        e_tok = mk_tok(K_INT, E_NONE, tstart, endpos, line, 1'b0);
                    M_HEX:
                        e_tok = mk_tok(K_HEX, E_NONE, tstart, endpos, line, 1'b0);
                    M_BIN:
                        e_tok = mk_tok(K_BIN, E_NONE, tstart, endpos, line, 1'b0);
                    M_NDOT:
                    begin
                        e_tok = mk_tok(K_INT, E_NONE, tstart, endpos - 1'b1, line, 1'b0);
                        for (int j = 0; j < MAX_RESULTS; j++)
                            if (push_n == 3'(j)) res[j] = e_tok;
                        push_n = push_n + 3'd1;
                        tstart = endpos - 1'b1;
                        e_tok = mk_tok(K_DOT, E_NONE, tstart, endpos, line, 1'b0);
                    end
                    M_FRAC, M_EXPD:
                        e_tok = mk_tok(K_FLOAT, E_NONE, tstart, endpos, line, 1'b0);
                    M_EXPS, M_EXPSIGN:
                        e_tok = mk_tok(K_ERROR, E_EXPONENT, tstart, endpos, line, 1'b0);
                    M_SO1, M_STR, M_SESC:
                        e_tok = mk_tok(K_ERROR, E_STR, tstart, endpos, line, 1'b0);
                    M_SO2:
                        e_tok = mk_tok(K_STRING, E_NONE, tstart, endpos, line, 1'b0);
                    M_RAW, M_RESC:
                        e_tok = mk_tok(K_ERROR, E_RAW, tstart, endpos, line, 1'b0);
                    M_CO, M_CHEX1, M_CDEC, M_CCLOSE:
                        e_tok = mk_tok(K_ERROR, E_CUNTERM, tstart, endpos, line, 1'b0);
                    M_CESC:
                        e_tok = mk_tok(K_ERROR, E_CESC, tstart, endpos, line, 1'b0);
                    M_CHEX0:
                        e_tok = mk_tok(K_ERROR, E_CHEX, tstart, endpos, line, 1'b0);
                    default:
                        e_do = 1'b0;
                endcase
                if (e_do)
                begin
                    for (int j = 0; j < MAX_RESULTS; j++)
                        if (push_n == 3'(j)) res[j] = e_tok;
                    push_n = push_n + 3'd1;
                end
                e_tok = mk_tok(K_END, E_NONE, endpos, endpos, line, 1'b1);
                for (int j = 0; j < MAX_RESULTS; j++)
                    if (push_n == 3'(j)) res[j] = e_tok;
                push_n = push_n + 3'd1;
                mode = M_IDLE;
                esc = 2'd0;
                ended_next = 1'b1;
            end
        end

        mode_next   = mode;
        tstart_next = tstart;
        pos_next    = pos;
        line_next   = line;
        word_next   = word;
        pend_next   = pend;
        esc_next    = esc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= M_IDLE;
            tstart_reg     <= '0;
            pos_reg        <= '0;
            line_reg       <= line_t'(1);
            word_reg       <= '0;
            pend_reg       <= 8'd0;
            esc_reg        <= 2'd0;
            ended_reg      <= 1'b0;
            held_valid_reg <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            mode_reg       <= mode_next;
            tstart_reg     <= tstart_next;
            pos_reg        <= pos_next;
            line_reg       <= line_next;
            word_reg       <= word_next;
            pend_reg       <= pend_next;
            esc_reg        <= esc_next;
            ended_reg      <= ended_next;
            held_valid_reg <= held_valid_next;
            wr_ptr_reg     <= wr_ptr_reg + QPTR_W'(push_n);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg      <= count_reg + QCNT_W'(push_n) - QCNT_W'(pop);
        end
    end

    // Payload storage: input hold register and token queue
    always_ff @(posedge clk)
    begin
        if (accept)
            held_item_reg <= byte_item;
        for (int j = 0; j < MAX_RESULTS; j++)
        begin
            if (3'(j) < push_n)
                queue_reg[wr_ptr_reg + QPTR_W'(j)] <= res[j];
        end
    end

endmodule

// ===== bench/source_text_tokenizer_test.sv =====
// Self-checking bench for the source text tokenizer: random source text and a token scoreboard.
`timescale 1ns / 1ps

module source_text_tokenizer_test;
    import stt_pkg::*;

    localparam int RUN_LIMIT  = 200000;
    localparam int TAIL_WAIT  = 40;
    localparam int BYTE_COUNT = 410;

    localparam logic [7:0] CH_NUL = 8'h00, CH_TAB = 8'h09, CH_NL = 8'h0A, CH_CR = 8'h0D;
    localparam logic [7:0] CH_DQ = 8'h22, CH_SQ = 8'h27, CH_BSL = 8'h5C;

    typedef enum int
    {
        S_IDLE, S_OP1, S_DOT2, S_LCOM, S_BCOM, S_BSTAR, S_WORD, S_NZERO, S_INT,
        S_HEX, S_BIN, S_NDOT, S_FRAC, S_EXPS, S_EXPSIGN, S_EXPD, S_SO1, S_SO2,
        S_STR, S_SESC, S_RAW, S_RESC, S_CO, S_CESC, S_CHEX0, S_CHEX1, S_CDEC,
        S_CCLOSE
    } lex_mode_e;

    class token_ledger;
        lex_mode_e   mode;
        logic [23:0] tok_start;
        logic [23:0] cursor;
        logic [19:0] line_no;
        logic [7:0]  word_chars [9];
        logic [7:0]  held_op;
        int          quote_cnt;
        bit          closed;
        int          burst;
        token_t      tokens_due [$];
        int          errors;
        string       kw_names [33] = '{
            "func", "let", "const", "return", "if", "else", "for", "while", "match",
            "extern", "struct", "static", "typealias", "defer", "break", "continue",
            "cast", "true", "false", "null", "u8", "i8", "char", "u16", "i16", "u32",
            "i32", "u64", "i64", "f32", "f64", "bool", "void"};

        function new();
            mode = S_IDLE;
            tok_start = '0;
            cursor = '0;
            line_no = 20'd1;
            foreach (word_chars[i]) word_chars[i] = 8'd0;
            held_op = 8'd0;
            quote_cnt = 0;
            closed = 0;
            errors = 0;
        endfunction

        function bit numeral(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit hexdig(logic [7:0] c);
            return numeral(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
        endfunction

        function void next_line();
            if (line_no != '1) line_no++;
        endfunction

        function void push_token(logic [6:0] kind, logic [3:0] err, logic [23:0] start,
                                 logic [23:0] len, logic last);
            token_t t;
            if (burst >= MAX_RESULTS) return;
            t.token_kind = kind;
            t.error_kind = err;
            t.start_offset = start;
            t.lexeme_length = len;
            t.line_number = line_no;
            t.last_token = last;
            tokens_due = {tokens_due, t};
            burst++;
        endfunction

        function void close_tok(logic [6:0] kind, logic [23:0] stop);
            push_token(kind, E_NONE, tok_start, stop - tok_start, 1'b0);
        endfunction

        function void close_err(logic [3:0] err, logic [23:0] stop);
            push_token(K_ERROR, err, tok_start, stop - tok_start, 1'b0);
        endfunction

        function void close_word(logic [23:0] stop);
            logic [23:0] len;
            logic [6:0]  kind;
            bit          same;
            len = stop - tok_start;
            kind = K_IDENT;
            if (len >= 1 && len <= 9)
            begin
                for (int k = 0; k < 33; k++)
                begin
                    if (kw_names[k].len() == len && kind == K_IDENT)
                    begin
                        same = 1;
                        for (int i = 0; i < len; i++)
                            if (word_chars[i] != kw_names[k][i]) same = 0;
                        if (same) kind = K_KW_BASE + 7'(k);
                    end
                end
            end
            close_tok(kind, stop);
        endfunction

        function logic [6:0] lone_op(logic [7:0] f);
            case (f)
                "+": return K_PLUS;
                "-": return K_MINUS;
                "*": return K_STAR;
                "/": return K_SLASH;
                "%": return K_PERCENT;
                "&": return K_AMP;
                "|": return K_PIPE;
                "^": return K_CARET;
                "!": return K_BANG;
                "=": return K_ASSIGN;
                "<": return K_LT;
                ">": return K_GT;
                default: return K_DOT;
            endcase
        endfunction

        // -1 when the two bytes are no operator
        function int paired_op(logic [7:0] f, logic [7:0] s);
            case (f)
                "+": return s == "+" ? K_INC : s == "=" ? K_PLUS_EQ : -1;
                "-": return s == "-" ? K_DEC : s == "=" ? K_MINUS_EQ : s == ">" ? K_ARROW : -1;
                "*": return s == "=" ? K_STAR_EQ : -1;
                "/": return s == "=" ? K_SLASH_EQ : -1;
                "%": return s == "=" ? K_PERCENT_EQ : -1;
                "&": return s == "=" ? K_AMP_EQ : s == "&" ? K_AND_AND : -1;
                "|": return s == "=" ? K_PIPE_EQ : s == "|" ? K_OR_OR : -1;
                "^": return s == "=" ? K_CARET_EQ : -1;
                "!": return s == "=" ? K_BANG_EQ : -1;
                "=": return s == "=" ? K_EQ_EQ : s == ">" ? K_FAT_ARROW : -1;
                "<": return s == "=" ? K_LT_EQ : s == "<" ? K_SHL : -1;
                ">": return s == "=" ? K_GT_EQ : s == ">" ? K_SHR : -1;
                default: return -1;
            endcase
        endfunction

        function void start_token(logic [7:0] c, logic [23:0] p);
            tok_start = p;
            case (c)
                "(": close_tok(K_LPAREN, p + 1);
                ")": close_tok(K_RPAREN, p + 1);
                "{": close_tok(K_LBRACE, p + 1);
                "}": close_tok(K_RBRACE, p + 1);
                "[": close_tok(K_LBRACK, p + 1);
                "]": close_tok(K_RBRACK, p + 1);
                ",": close_tok(K_COMMA, p + 1);
                ":": close_tok(K_COLON, p + 1);
                ";": close_tok(K_SEMI, p + 1);
                "?": close_tok(K_QUEST, p + 1);
                "_": close_tok(K_UNDERSCORE, p + 1);
                ".", "+", "-", "*", "/", "%", "&", "|", "^", "!", "=", "<", ">":
                begin
                    held_op = c;
                    mode = S_OP1;
                end
                CH_DQ: mode = S_SO1;
                CH_SQ: mode = S_CO;
                " ", CH_CR, CH_TAB: ;
                CH_NL: next_line();
                default:
                begin
                    if (letter(c))
                    begin
                        foreach (word_chars[i]) word_chars[i] = 8'd0;
                        word_chars[0] = c;
                        mode = S_WORD;
                    end
                    else if (numeral(c))
                        mode = (c == "0") ? S_NZERO : S_INT;
                    else
                        close_err(E_UNEXPECTED, p + 1);
                end
            endcase
        endfunction

        // Rescan the byte in the new mode whenever a mode hands it on without taking it
        function void scan(logic [7:0] c, logic [23:0] p);
            bit          again;
            int          k;
            logic [23:0] idx;
            do
            begin
                again = 0;
                case (mode)
                    S_OP1:
                    begin
                        if (held_op == "." && c == ".") mode = S_DOT2;
                        else if (held_op == "/" && c == "/") mode = S_LCOM;
                        else if (held_op == "/" && c == "*") mode = S_BCOM;
                        else
                        begin
                            k = paired_op(held_op, c);
                            mode = S_IDLE;
                            if (k >= 0) close_tok(k[6:0], p + 1);
                            else
                            begin
                                close_tok(lone_op(held_op), p);
                                again = 1;
                            end
                        end
                    end
                    S_DOT2:
                    begin
                        mode = S_IDLE;
                        if (c == ".") close_tok(K_ELLIPSIS, p + 1);
                        else
                        begin
                            close_tok(K_RANGE, p);
                            again = 1;
                        end
                    end
                    S_LCOM:
                        if (c == CH_NL)
                        begin
                            next_line();
                            mode = S_IDLE;
                        end
                    S_BCOM:
                        if (c == "*") mode = S_BSTAR;
                        else if (c == CH_NL) next_line();
                    S_BSTAR:
                        if (c == "/") mode = S_IDLE;
                        else if (c != "*")
                        begin
                            mode = S_BCOM;
                            if (c == CH_NL) next_line();
                        end
                    S_WORD:
                        if (letter(c) || numeral(c) || c == "_")
                        begin
                            idx = p - tok_start;
                            if (idx < 9) word_chars[idx] = c;
                        end
                        else
                        begin
                            close_word(p);
                            mode = S_IDLE;
                            again = 1;
                        end
                    S_NZERO:
                        if (c == "x" || c == "X") mode = S_HEX;
                        else if (c == "b" || c == "B") mode = S_BIN;
                        else
                        begin
                            mode = S_INT;
                            again = 1;
                        end
                    S_INT:
                        if (numeral(c)) ;
                        else if (c == ".") mode = S_NDOT;
                        else if (c == "e" || c == "E") mode = S_EXPS;
                        else
                        begin
                            close_tok(K_INT, p);
                            mode = S_IDLE;
                            again = 1;
                        end
                    S_HEX:
                        if (!hexdig(c))
                        begin
                            close_tok(K_HEX, p);
                            mode = S_IDLE;
                            again = 1;
                        end
                    S_BIN:
                        if (c != "0" && c != "1")
                        begin
                            close_tok(K_BIN, p);
                            mode = S_IDLE;
                            again = 1;
                        end
                    S_NDOT:
                        if (numeral(c)) mode = S_FRAC;
                        else
                        begin
                            // hand the held dot back as an operator
                            close_tok(K_INT, p - 1);
                            tok_start = p - 1;
                            held_op = ".";
                            mode = S_OP1;
                            again = 1;
                        end
                    S_FRAC:
                        if (numeral(c)) ;
                        else if (c == "e" || c == "E") mode = S_EXPS;
                        else
                        begin
                            close_tok(K_FLOAT, p);
                            mode = S_IDLE;
                            again = 1;
                        end
                    S_EXPS:
                        if (c == "+" || c == "-") mode = S_EXPSIGN;
                        else if (numeral(c)) mode = S_EXPD;
                        else
                        begin
                            close_err(E_EXPONENT, p);
                            mode = S_IDLE;
                            again = 1;
                        end
                    S_EXPSIGN:
                        if (numeral(c)) mode = S_EXPD;
                        else
                        begin
                            close_err(E_EXPONENT, p);
                            mode = S_IDLE;
                            again = 1;
                        end
                    S_EXPD:
                        if (!numeral(c))
                        begin
                            close_tok(K_FLOAT, p);
                            mode = S_IDLE;
                            again = 1;
                        end
                    S_SO1:
                        if (c == CH_DQ) mode = S_SO2;
                        else
                        begin
                            mode = S_STR;
                            again = 1;
                        end
                    S_SO2:
                        if (c == CH_DQ)
                        begin
                            mode = S_RAW;
                            quote_cnt = 0;
                        end
                        else
                        begin
                            close_tok(K_STRING, p);
                            mode = S_IDLE;
                            again = 1;
                        end
                    S_STR:
                        if (c == CH_DQ)
                        begin
                            close_tok(K_STRING, p + 1);
                            mode = S_IDLE;
                        end
                        else if (c == CH_NL)
                        begin
                            close_err(E_STR, p);
                            mode = S_IDLE;
                            again = 1;
                        end
                        else if (c == CH_BSL) mode = S_SESC;
                    S_SESC:
                    begin
                        mode = S_STR;
                        if (c != CH_DQ && c != CH_BSL) again = 1;
                    end
                    S_RAW:
                        if (c == CH_DQ)
                        begin
                            if (quote_cnt >= 2)
                            begin
                                close_tok(K_STRING, p + 1);
                                mode = S_IDLE;
                                quote_cnt = 0;
                            end
                            else quote_cnt++;
                        end
                        else
                        begin
                            quote_cnt = 0;
                            if (c == CH_BSL) mode = S_RESC;
                            else if (c == CH_NL) next_line();
                        end
                    S_RESC:
                    begin
                        mode = S_RAW;
                        if (c != CH_DQ && c != CH_BSL) again = 1;
                    end
                    S_CO:
                        if (c == CH_BSL) mode = S_CESC;
                        else if (c >= 8'h20 && c <= 8'h7E && c != CH_SQ) mode = S_CCLOSE;
                        else
                        begin
                            mode = S_IDLE;
                            close_err(c == CH_SQ ? E_CEMPTY : c == CH_NL ? E_CUNTERM : E_CINVALID, p);
                            again = 1;
                        end
                    S_CESC:
                        if (c == "n" || c == "r" || c == "t" || c == CH_BSL || c == CH_SQ || c == CH_DQ)
                            mode = S_CCLOSE;
                        else if (c == "x") mode = S_CHEX0;
                        else if (numeral(c))
                        begin
                            mode = S_CDEC;
                            quote_cnt = 1;
                        end
                        else
                        begin
                            close_err(E_CESC, p);
                            mode = S_IDLE;
                            again = 1;
                        end
                    S_CHEX0:
                        if (hexdig(c)) mode = S_CHEX1;
                        else
                        begin
                            close_err(E_CHEX, p);
                            mode = S_IDLE;
                            again = 1;
                        end
                    S_CHEX1:
                    begin
                        mode = S_CCLOSE;
                        if (!hexdig(c)) again = 1;
                    end
                    S_CDEC:
                        if (numeral(c))
                        begin
                            quote_cnt++;
                            if (quote_cnt >= 3)
                            begin
                                mode = S_CCLOSE;
                                quote_cnt = 0;
                            end
                        end
                        else
                        begin
                            mode = S_CCLOSE;
                            quote_cnt = 0;
                            again = 1;
                        end
                    S_CCLOSE:
                    begin
                        mode = S_IDLE;
                        if (c == CH_SQ) close_tok(K_CHAR, p + 1);
                        else
                        begin
                            close_err(E_CUNTERM, p);
                            again = 1;
                        end
                    end
                    default:
                    begin
                        mode = S_IDLE;
                        start_token(c, p);
                    end
                endcase
            end
            while (again);
        endfunction

        function void end_source();
            case (mode)
                S_OP1: close_tok(lone_op(held_op), cursor);
                S_DOT2: close_tok(K_RANGE, cursor);
                S_WORD: close_word(cursor);
                S_NZERO, S_INT: close_tok(K_INT, cursor);
                S_HEX: close_tok(K_HEX, cursor);
                S_BIN: close_tok(K_BIN, cursor);
                S_NDOT:
                begin
                    close_tok(K_INT, cursor - 1);
                    tok_start = cursor - 1;
                    close_tok(K_DOT, cursor);
                end
                S_FRAC, S_EXPD: close_tok(K_FLOAT, cursor);
                S_EXPS, S_EXPSIGN: close_err(E_EXPONENT, cursor);
                S_SO1, S_STR, S_SESC: close_err(E_STR, cursor);
                S_SO2: close_tok(K_STRING, cursor);
                S_RAW, S_RESC: close_err(E_RAW, cursor);
                S_CO, S_CHEX1, S_CDEC, S_CCLOSE: close_err(E_CUNTERM, cursor);
                S_CESC: close_err(E_CESC, cursor);
                S_CHEX0: close_err(E_CHEX, cursor);
                default: ;
            endcase
            mode = S_IDLE;
            quote_cnt = 0;
            push_token(K_END, E_NONE, cursor, 24'd0, 1'b1);
            closed = 1;
        endfunction

        function void note_byte(byte_item_t it);
            burst = 0;
            if (closed) return;
            if (it.source_byte == CH_NUL)
            begin
                end_source();
                return;
            end
            scan(it.source_byte, cursor);
            cursor++;
            if (it.end_of_source) end_source();
        endfunction

        function void check_token(token_t got);
            token_t want;
            if (tokens_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected token kind=%0d start=%0d len=%0d",
                             got.token_kind, got.start_offset, got.lexeme_length);
                return;
            end
            want = tokens_due.pop_front();
            if (got.token_kind !== want.token_kind || got.error_kind !== want.error_kind ||
                got.start_offset !== want.start_offset ||
                got.lexeme_length !== want.lexeme_length ||
                got.line_number !== want.line_number || got.last_token !== want.last_token)
            begin
                errors++;
                if (errors <= 10)
                    $display("token mismatch: exp kind=%0d err=%0d start=%0d len=%0d line=%0d last=%0d, got kind=%0d err=%0d start=%0d len=%0d line=%0d last=%0d",
                             want.token_kind, want.error_kind, want.start_offset,
                             want.lexeme_length, want.line_number, want.last_token,
                             got.token_kind, got.error_kind, got.start_offset,
                             got.lexeme_length, got.line_number, got.last_token);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       byte_valid;
    logic       byte_stall;
    byte_item_t byte_item;
    logic       token_valid;
    logic       token_stall = 1'b0;
    token_t     token_item;

    token_ledger ledger = new();
    bit          calm;
    int          cycles;
    byte         src [$];

    source_text_tokenizer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .token_valid(token_valid),
        .token_stall(token_stall),
        .token_item (token_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        token_stall <= !calm && ($urandom_range(99) < 19);
        if (rst_n && token_valid && !token_stall)
            ledger.check_token(token_item);
    end

    function automatic string pick_fragment();
        string s;
        string ops [] = '{"(", ")", "{", "}", "[", "]", ",", ".", "...", "..", ":", ";",
                          "?", "+", "++", "+=", "-", "--", "-=", "->", "*", "*=", "/",
                          "/=", "%", "%=", "&", "&=", "&&", "|", "|=", "||", "^", "^=",
                          "!", "!=", "=", "==", "=>", "<", "<=", "<<", ">", ">=", ">>",
                          "_", "// note\n", "/* a ** b\n */", "//\n"};
        string lits [] = '{"\"ab\\\"c\\\\\"", "\"\"\"r\"\"a\\\"w\"\"\"", "\"x\n",
                           "\"\"", "'a'", "'\\n'", "'\\x4f'", "'\\x4'", "'\\123'",
                           "'\\7'", "'\\q'", "''", "'ab", "'\\xg'", "'\n", "\"\"\"\n\"\"\"",
                           "'\\''", "\"t\\q\""};
        string nums [] = '{"0", "0x1fA", "0Xff", "0b101", "0B1", "1.25", "3.5e+12",
                           "7e9", "2E-4", "1e+x", "4ex", "9.", "5..7", "0.1e", "08"};
        string kws [] = '{"func", "let", "const", "return", "if", "else", "for", "while",
                          "match", "extern", "struct", "static", "typealias", "defer",
                          "break", "continue", "cast", "true", "false", "null", "u8",
                          "i8", "char", "u16", "i16", "u32", "i32", "u64", "i64", "f32",
                          "f64", "bool", "void", "typealiasx", "fun", "Func"};
        string alnum = "abcxyzABZ09_";
        string ws = " \t \n";
        int n;
        ws.putc(2, CH_CR);
        case ($urandom_range(9))
            0, 1: s = kws[$urandom_range(kws.size() - 1)];
            2:
            begin
                n = $urandom_range(1, 12);
                s = "q";
                for (int i = 1; i < n; i++) s = {s, alnum.substr($urandom_range(11), $urandom_range(11))};
                s = {s, " "};
            end
            3, 4: s = ops[$urandom_range(ops.size() - 1)];
            5: s = nums[$urandom_range(nums.size() - 1)];
            6: s = lits[$urandom_range(lits.size() - 1)];
            7, 8:
            begin
                n = $urandom_range(1, 3);
                s = "";
                for (int i = 0; i < n; i++)
                begin
                    int j;
                    j = $urandom_range(3);
                    s = {s, ws.substr(j, j)};
                end
            end
            default:
            begin
                // noise: any byte but NUL
                s = " ";
                s.putc(0, 8'($urandom_range(1, 255)));
            end
        endcase
        return s;
    endfunction

    task automatic send_byte(input byte_item_t it);
        byte_item <= it;
        byte_valid <= 1'b1;
        do @(posedge clk); while (byte_stall);
        ledger.note_byte(it);
    endtask

    initial
    begin
        string       text;
        byte_item_t  it;
        bit          nul_end;
        int          gap;
        rst_n <= 1'b0;
        byte_valid <= 1'b0;
        byte_item <= '0;
        calm = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed opening: dot after digits, lone underscore, empty string, bad exponent, char
        text = "1..2 _a\"\"x 0b1 1e+ 'A'\xff;";
        while (src.size() + text.len() < BYTE_COUNT)
        begin
            for (int i = 0; i < text.len(); i++) src = {src, text[i]};
            text = pick_fragment();
        end
        nul_end = $urandom_range(1);

        foreach (src[i])
        begin
            calm = (i >= 150 && i < 250);
            it.source_byte = src[i];
            it.end_of_source = !nul_end && (i == src.size() - 1);
            send_byte(it);
            if (!calm && $urandom_range(99) < 19)
            begin
                byte_valid <= 1'b0;
                gap = $urandom_range(1, 3);
                repeat (gap) @(posedge clk);
            end
        end
        calm = 0;
        if (nul_end)
        begin
            it.source_byte = CH_NUL;
            it.end_of_source = 1'b1;
            send_byte(it);
        end
        // bytes after the end are taken and dropped
        for (int i = 0; i < 3; i++)
        begin
            it.source_byte = 8'($urandom_range(255));
            it.end_of_source = 1'($urandom_range(1));
            send_byte(it);
        end
        byte_valid <= 1'b0;

        while (ledger.tokens_due.size() != 0) @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        if (ledger.errors == 0 && ledger.tokens_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
design/stt_pkg.sv
design/source_text_tokenizer.sv
bench/source_text_tokenizer_test.sv
